/* rtl/ttenc_pkg.sv */
`timescale 1ns / 1ps
package ttenc_pkg;

   // field widths
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 12;
   localparam int VAL_W     = 10;
   localparam int THR_W     = 6;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int WORD_W    = VAL_W + THR_W + 1;

   // default geometry limits
   localparam int DEF_MAX_GRID_WIDTH  = 64;
   localparam int DEF_MAX_GRID_HEIGHT = 64;
   localparam int DEF_MAX_LEVELS      = 7;

   // item commands
   localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   // value of a node that no leaf has lowered yet
   localparam logic [VAL_W-1:0] INIT_VALUE = 10'd999;

   // largest grid side a register can hold
   function automatic int dim_lim(input int maxdim, input int maxlev);
      int lim;
      lim = 1 << (maxlev - 1);
      if (maxdim < lim) lim = maxdim;
      if (lim > (1 << DIM_W) - 1) lim = (1 << DIM_W) - 1;
      return lim;
   endfunction

   // total node count of the largest tree
   function automatic int node_depth(input int mw, input int mh, input int ml);
      int w;
      int h;
      int n;
      int tot;
      int l;
      w   = dim_lim(mw, ml);
      h   = dim_lim(mh, ml);
      tot = 0;
      l   = 0;
      do begin
         n   = w * h;
         tot = tot + n;
         w   = (w + 1) >> 1;
         h   = (h + 1) >> 1;
         l   = l + 1;
      end while (n > 1 && l < 32);
      return tot;
   endfunction

   typedef struct packed {
      logic geo_start;
      logic geo_step;
      logic clr_start;
      logic clr_step;
      logic load_item;
      logic div_step;
      logic lvl_init_top;
      logic lvl_init_leaf;
      logic lvl_up;
      logic lvl_down;
      logic calc_addr;
      logic load_node;
      logic set_write;
      logic emit;
      logic enc_write;
      logic flush;
   } ttenc_cmd_type;

   typedef struct packed {
      logic geo_last;
      logic clr_last;
      logic leaf_ok;
      logic div_last;
      logic set_stop;
      logic lvl_top;
      logic lvl_bottom;
      logic emit_stop;
      logic emit_hit;
      logic can_push;
      logic pend_valid;
   } ttenc_stat_type;

endpackage

/* rtl/ttenc_ram.sv */
`timescale 1ns / 1ps
module ttenc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ttenc_ctrl.sv */
`timescale 1ns / 1ps
module ttenc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ttenc_pkg::CMD_W-1:0]   req_cmd,
   output logic                          req_ready,
   input  logic                          csr_valid,
   input  logic [ttenc_pkg::CSR_IDX_W-1:0] csr_index,
   input  ttenc_pkg::ttenc_stat_type     stat,
   output ttenc_pkg::ttenc_cmd_type      cmd
);
   import ttenc_pkg::*;

   localparam logic [3:0] S_GEO_INIT = 4'd0;
   localparam logic [3:0] S_GEO      = 4'd1;
   localparam logic [3:0] S_CLR      = 4'd2;
   localparam logic [3:0] S_IDLE     = 4'd3;
   localparam logic [3:0] S_CHK      = 4'd4;
   localparam logic [3:0] S_DIV      = 4'd5;
   localparam logic [3:0] S_ADDR     = 4'd6;
   localparam logic [3:0] S_RD       = 4'd7;
   localparam logic [3:0] S_LOAD     = 4'd8;
   localparam logic [3:0] S_SET      = 4'd9;
   localparam logic [3:0] S_EMIT     = 4'd10;
   localparam logic [3:0] S_WR       = 4'd11;
   localparam logic [3:0] S_FLUSH    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       enc_ff, enc_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      enc_in    = enc_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_GEO_INIT: begin
            cmd.geo_start = 1'b1;
            cmd.clr_start = 1'b1;
            state_in      = S_GEO;
         end
         S_GEO: begin
            cmd.geo_step = 1'b1;
            if (stat.geo_last) state_in = S_CLR;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               unique case (req_cmd)
                  CMD_RESET: begin
                     cmd.clr_start = 1'b1;
                     state_in      = S_CLR;
                  end
                  CMD_SET: begin
                     enc_in   = 1'b0;
                     state_in = S_CHK;
                  end
                  CMD_ENCODE: begin
                     enc_in   = 1'b1;
                     state_in = S_CHK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHK: begin
            if (stat.leaf_ok) begin
               cmd.lvl_init_top  = enc_ff;
               cmd.lvl_init_leaf = !enc_ff;
               state_in          = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_ADDR;
         end
         S_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_RD;
         end
         S_RD: state_in = S_LOAD;
         S_LOAD: begin
            cmd.load_node = 1'b1;
            state_in      = enc_ff ? S_EMIT : S_SET;
         end
         S_SET: begin
            if (stat.set_stop) begin
               state_in = S_IDLE;
            end else begin
               cmd.set_write = 1'b1;
               if (stat.lvl_top) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.lvl_up = 1'b1;
                  state_in   = S_ADDR;
               end
            end
         end
         S_EMIT: begin
            if (stat.emit_stop) begin
               state_in = S_WR;
            end else if (!stat.pend_valid || stat.can_push) begin
               cmd.emit = 1'b1;
               if (stat.emit_hit) state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.enc_write = 1'b1;
            if (stat.lvl_bottom) begin
               state_in = S_FLUSH;
            end else begin
               cmd.lvl_down = 1'b1;
               state_in     = S_ADDR;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (!stat.pend_valid || stat.can_push) state_in = S_IDLE;
         end
         default: state_in = S_GEO_INIT;
      endcase
      // new geometry rebuilds and clears the tree
      if (csr_valid && (csr_index == CSR_GRID_WIDTH || csr_index == CSR_GRID_HEIGHT)) begin
         state_in = S_GEO_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_GEO_INIT;
         enc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         enc_ff   <= enc_in;
      end
   end
endmodule

/* rtl/ttenc_dp.sv */
`timescale 1ns / 1ps
module ttenc_dp #(
   parameter int MAX_GRID_WIDTH  = ttenc_pkg::DEF_MAX_GRID_WIDTH,
   parameter int MAX_GRID_HEIGHT = ttenc_pkg::DEF_MAX_GRID_HEIGHT,
   parameter int MAX_LEVELS      = ttenc_pkg::DEF_MAX_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ttenc_pkg::ttenc_cmd_type        cmd,
   output ttenc_pkg::ttenc_stat_type       stat,
   input  logic [ttenc_pkg::IDX_W-1:0]     req_leaf_index,
   input  logic [ttenc_pkg::VAL_W-1:0]     req_leaf_value,
   input  logic [ttenc_pkg::THR_W-1:0]     req_threshold,
   input  logic                            csr_valid,
   input  logic [ttenc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ttenc_pkg::DIM_W-1:0]     csr_wdata,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_bit_res,
   output logic                            rsp_last
);
   import ttenc_pkg::*;

   localparam int LIM_W = dim_lim(MAX_GRID_WIDTH, MAX_LEVELS);
   localparam int LIM_H = dim_lim(MAX_GRID_HEIGHT, MAX_LEVELS);
   localparam int DEPTH = node_depth(MAX_GRID_WIDTH, MAX_GRID_HEIGHT, MAX_LEVELS);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW    = $clog2(DEPTH + 1);
   localparam int XB    = (LIM_W > 1) ? $clog2(LIM_W) : 1;
   localparam int YB    = (LIM_H > 1) ? $clog2(LIM_H) : 1;
   localparam int SB    = (YB > 1) ? $clog2(YB) : 1;
   localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CW    = $clog2(MAX_LEVELS + 1);
   localparam int NW    = 2 * DIM_W;
   localparam int CMPW  = (IDX_W > NW) ? IDX_W : NW;
   localparam int TW    = IDX_W + DIM_W;
   localparam int PW    = YB + DIM_W;
   localparam logic [DIM_W-1:0] LIM_W_V = DIM_W'(LIM_W);
   localparam logic [DIM_W-1:0] LIM_H_V = DIM_W'(LIM_H);
   localparam logic [THR_W-1:0] THR_CAP = THR_W'(63 - MAX_LEVELS);

   // geometry registers
   logic [DIM_W-1:0] grid_w_ff, grid_w_in, grid_h_ff, grid_h_in;
   logic [DIM_W-1:0] geo_w_ff, geo_w_in, geo_h_ff, geo_h_in;
   logic [OW-1:0]    geo_off_ff, geo_off_in;
   logic [LW-1:0]    geo_lvl_ff, geo_lvl_in;
   logic [DIM_W-1:0] lvl_w_ff [MAX_LEVELS];
   logic [DIM_W-1:0] lvl_w_in [MAX_LEVELS];
   logic [AW-1:0]    lvl_off_ff [MAX_LEVELS];
   logic [AW-1:0]    lvl_off_in [MAX_LEVELS];
   logic [CW-1:0]    lvl_cnt_ff, lvl_cnt_in;
   logic [NW-1:0]    leaf_cnt_ff, leaf_cnt_in;
   logic [NW-1:0]    geo_n;

   // item and walk registers
   logic [AW-1:0]    clr_ctr_ff, clr_ctr_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [YB-1:0]    quo_ff, quo_in;
   logic [SB-1:0]    dstep_ff, dstep_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [LW-1:0]    lvl_ff, lvl_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [VAL_W-1:0] cur_value_ff, cur_value_in;
   logic [THR_W-1:0] cur_low_ff, cur_low_in;
   logic             cur_known_ff, cur_known_in;
   logic [THR_W-1:0] run_low_ff, run_low_in;

   // output side
   logic pend_valid_ff, pend_valid_in, pend_bit_ff, pend_bit_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_bit_ff, rsp_bit_in, rsp_last_ff, rsp_last_in;

   // node store
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic [VAL_W-1:0]  rd_value;
   logic [THR_W-1:0]  rd_low;

   logic [TW-1:0]    trial;
   logic             trial_ge;
   logic [XB-1:0]    xs;
   logic [YB-1:0]    ys;
   logic [PW-1:0]    prod;
   logic [AW-1:0]    addr_calc;
   logic             low_reached, thr_done, can_push, push;
   logic [DIM_W-1:0] csr_clamp_w, csr_clamp_h;

   assign geo_n     = NW'(geo_w_ff) * NW'(geo_h_ff);
   assign trial     = TW'(grid_w_ff) << dstep_ff;
   assign trial_ge  = TW'(rem_ff) >= trial;
   assign xs        = rem_ff[XB-1:0] >> lvl_ff;
   assign ys        = quo_ff >> lvl_ff;
   assign prod      = PW'(ys) * PW'(lvl_w_ff[lvl_ff]);
   assign addr_calc = lvl_off_ff[lvl_ff] + AW'(prod) + AW'(xs);
   assign rd_value  = ram_rdata[WORD_W-1 -: VAL_W];
   assign rd_low    = ram_rdata[THR_W:1];
   assign low_reached = VAL_W'(run_low_ff) >= cur_value_ff;
   assign thr_done  = run_low_ff >= thr_ff;
   assign can_push  = !rsp_valid_ff || rsp_ready;
   assign push      = (cmd.emit && pend_valid_ff) || (cmd.flush && pend_valid_ff && can_push);

   assign csr_clamp_w = (csr_wdata == '0) ? DIM_W'(1) :
                        ((csr_wdata > LIM_W_V) ? LIM_W_V : csr_wdata);
   assign csr_clamp_h = (csr_wdata == '0) ? DIM_W'(1) :
                        ((csr_wdata > LIM_H_V) ? LIM_H_V : csr_wdata);

   always_comb begin
      stat.geo_last   = (geo_n == NW'(1)) || (geo_lvl_ff == LW'(MAX_LEVELS - 1));
      stat.clr_last   = (clr_ctr_ff == AW'(DEPTH - 1));
      stat.leaf_ok    = CMPW'(rem_ff) < CMPW'(leaf_cnt_ff);
      stat.div_last   = (dstep_ff == '0);
      stat.set_stop   = cur_value_ff <= val_ff;
      stat.lvl_top    = (CW'(lvl_ff) + CW'(1)) == lvl_cnt_ff;
      stat.lvl_bottom = (lvl_ff == '0);
      stat.emit_stop  = thr_done || (low_reached && cur_known_ff);
      stat.emit_hit   = low_reached;
      stat.can_push   = can_push;
      stat.pend_valid = pend_valid_ff;
   end

   always_comb begin
      grid_w_in    = grid_w_ff;
      grid_h_in    = grid_h_ff;
      geo_w_in     = geo_w_ff;
      geo_h_in     = geo_h_ff;
      geo_off_in   = geo_off_ff;
      geo_lvl_in   = geo_lvl_ff;
      lvl_w_in     = lvl_w_ff;
      lvl_off_in   = lvl_off_ff;
      lvl_cnt_in   = lvl_cnt_ff;
      leaf_cnt_in  = leaf_cnt_ff;
      clr_ctr_in   = clr_ctr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dstep_in     = dstep_ff;
      val_in       = val_ff;
      thr_in       = thr_ff;
      lvl_in       = lvl_ff;
      addr_in      = addr_ff;
      cur_value_in = cur_value_ff;
      cur_low_in   = cur_low_ff;
      cur_known_in = cur_known_ff;
      run_low_in   = run_low_ff;
      pend_valid_in = pend_valid_ff;
      pend_bit_in  = pend_bit_ff;
      rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_bit_in   = push ? pend_bit_ff : rsp_bit_ff;
      rsp_last_in  = push ? cmd.flush : rsp_last_ff;

      if (csr_valid && csr_index == CSR_GRID_WIDTH) grid_w_in = csr_clamp_w;
      if (csr_valid && csr_index == CSR_GRID_HEIGHT) grid_h_in = csr_clamp_h;

      if (cmd.geo_start) begin
         geo_w_in   = grid_w_ff;
         geo_h_in   = grid_h_ff;
         geo_off_in = '0;
         geo_lvl_in = '0;
      end
      if (cmd.geo_step) begin
         lvl_w_in[geo_lvl_ff]   = geo_w_ff;
         lvl_off_in[geo_lvl_ff] = AW'(geo_off_ff);
         if (geo_lvl_ff == '0) leaf_cnt_in = geo_n;
         geo_off_in = geo_off_ff + OW'(geo_n);
         geo_w_in   = DIM_W'(((DIM_W + 1)'(geo_w_ff) + (DIM_W + 1)'(1)) >> 1);
         geo_h_in   = DIM_W'(((DIM_W + 1)'(geo_h_ff) + (DIM_W + 1)'(1)) >> 1);
         geo_lvl_in = geo_lvl_ff + LW'(1);
         lvl_cnt_in = CW'(geo_lvl_ff) + CW'(1);
      end

      if (cmd.clr_start) clr_ctr_in = '0;
      if (cmd.clr_step) clr_ctr_in = clr_ctr_ff + AW'(1);

      if (cmd.load_item) begin
         rem_in   = req_leaf_index;
         quo_in   = '0;
         dstep_in = SB'(YB - 1);
         val_in   = req_leaf_value;
         thr_in   = (req_threshold > THR_CAP) ? THR_CAP : req_threshold;
      end
      // one quotient bit per step
      if (cmd.div_step) begin
         if (trial_ge) begin
            rem_in           = rem_ff - IDX_W'(trial);
            quo_in[dstep_ff] = 1'b1;
         end
         dstep_in = dstep_ff - SB'(1);
      end

      if (cmd.lvl_init_leaf) lvl_in = '0;
      if (cmd.lvl_init_top) begin
         lvl_in     = LW'(lvl_cnt_ff - CW'(1));
         run_low_in = '0;
      end
      if (cmd.lvl_up) lvl_in = lvl_ff + LW'(1);
      if (cmd.lvl_down) lvl_in = lvl_ff - LW'(1);
      if (cmd.calc_addr) addr_in = addr_calc;

      if (cmd.load_node) begin
         cur_value_in = rd_value;
         cur_low_in   = rd_low;
         cur_known_in = ram_rdata[0];
         run_low_in   = (rd_low > run_low_ff) ? rd_low : run_low_ff;
      end

      if (cmd.emit) begin
         pend_valid_in = 1'b1;
         pend_bit_in   = low_reached;
         if (low_reached) cur_known_in = 1'b1;
         else run_low_in = run_low_ff + THR_W'(1);
      end
      if (cmd.flush && can_push) pend_valid_in = 1'b0;
   end

   always_comb begin
      ram_we    = cmd.clr_step || cmd.set_write || cmd.enc_write;
      ram_waddr = cmd.clr_step ? clr_ctr_ff : addr_ff;
      priority if (cmd.clr_step) ram_wdata = {INIT_VALUE, THR_W'(0), 1'b0};
      else if (cmd.set_write) ram_wdata = {val_ff, cur_low_ff, cur_known_ff};
      else ram_wdata = {cur_value_ff, run_low_ff, cur_known_ff};
   end

   ttenc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(addr_ff),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff     <= DIM_W'(1);
         grid_h_ff     <= DIM_W'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         grid_w_ff     <= grid_w_in;
         grid_h_ff     <= grid_h_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      geo_w_ff     <= geo_w_in;
      geo_h_ff     <= geo_h_in;
      geo_off_ff   <= geo_off_in;
      geo_lvl_ff   <= geo_lvl_in;
      lvl_w_ff     <= lvl_w_in;
      lvl_off_ff   <= lvl_off_in;
      lvl_cnt_ff   <= lvl_cnt_in;
      leaf_cnt_ff  <= leaf_cnt_in;
      clr_ctr_ff   <= clr_ctr_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dstep_ff     <= dstep_in;
      val_ff       <= val_in;
      thr_ff       <= thr_in;
      lvl_ff       <= lvl_in;
      addr_ff      <= addr_in;
      cur_value_ff <= cur_value_in;
      cur_low_ff   <= cur_low_in;
      cur_known_ff <= cur_known_in;
      run_low_ff   <= run_low_in;
      pend_bit_ff  <= pend_bit_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bit_res = rsp_bit_ff;
   assign rsp_last    = rsp_last_ff;
endmodule

/* rtl/tag_tree_encoder_top.sv */
`timescale 1ns / 1ps
// set item: leaf check and divide, then address, read, load and write for each level walked up from the leaf
// encode item: leaf check and divide, then per level from the top address, read, load, a bit loop (ended
//   by a one bit, the threshold or a known node) and write back, then a flush releases the final bit
// one item at a time; rsp register lets the next item start while the last bit waits
// reset and geometry register writes: geometry build (up to max levels), then a clearing
//   pass of one node per cycle over all 5461 nodes at default size; tree reset item does the pass too
module tag_tree_encoder_top #(
   parameter int MAX_GRID_WIDTH  = ttenc_pkg::DEF_MAX_GRID_WIDTH,
   parameter int MAX_GRID_HEIGHT = ttenc_pkg::DEF_MAX_GRID_HEIGHT,
   parameter int MAX_LEVELS      = ttenc_pkg::DEF_MAX_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ttenc_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ttenc_pkg::IDX_W-1:0]     req_leaf_index,
   input  logic [ttenc_pkg::VAL_W-1:0]     req_leaf_value,
   input  logic [ttenc_pkg::THR_W-1:0]     req_threshold,
   // coded bits out
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_bit_res,
   output logic                            rsp_last,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ttenc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ttenc_pkg::DIM_W-1:0]     csr_wdata
);
   import ttenc_pkg::*;

   ttenc_cmd_type  cmd;
   ttenc_stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: geometry build, clear, divide, per-level walk, bit loop
   ttenc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_cmd  (req_cmd),
      .req_ready(req_ready),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .stat     (stat),
      .cmd      (cmd)
   );

   // node store, level tables, divider and output staging
   ttenc_dp #(
      .MAX_GRID_WIDTH (MAX_GRID_WIDTH),
      .MAX_GRID_HEIGHT(MAX_GRID_HEIGHT),
      .MAX_LEVELS     (MAX_LEVELS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_leaf_index(req_leaf_index),
      .req_leaf_value(req_leaf_value),
      .req_threshold (req_threshold),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_bit_res   (rsp_bit_res),
      .rsp_last      (rsp_last)
   );

   // a held-back bit must be released before the next item starts
   a_pend_blocks_req: assert property (@(posedge clock) disable iff (reset)
      stat.pend_valid |-> !req_ready)
      else $error("item accepted with a coded bit still held back");

   // a geometry write always rebuilds and clears before new items
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == CSR_GRID_WIDTH || csr_index == CSR_GRID_HEIGHT)) |=> !req_ready)
      else $error("item path open right after geometry write");

   // emitting over a full output stage would drop a bit
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!stat.pend_valid || stat.can_push))
      else $error("bit emitted with no room in output stage");
endmodule

/* tb/sv/tag_tree_encoder_checker.sv */
`timescale 1ns / 1ps
module tag_tree_encoder_checker
   import ttenc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [IDX_W-1:0]     req_leaf_index,
   input  logic [VAL_W-1:0]     req_leaf_value,
   input  logic [THR_W-1:0]     req_threshold,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_bit_res,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output int                   pending_bits,
   output int                   bits_checked,
   output int                   errors
);

   localparam int NODE_SLOTS = 5781;
   localparam int SIDE_LIM   = 64;
   localparam int THR_LIM    = 63 - DEF_MAX_LEVELS;

   typedef struct packed {
      logic bit_res;
      logic last;
   } coded_bit_type;

   coded_bit_type coded_q[$];
   int          grid_w;
   int          grid_h;
   logic [VAL_W-1:0] tree_value [NODE_SLOTS];
   logic [5:0]       tree_low   [NODE_SLOTS];
   logic             tree_known [NODE_SLOTS];
   int          lvl_w   [32];
   int          lvl_off [32];
   int          lvl_num;

   assign pending_bits = coded_q.size();

   function automatic int clamp_side(input int v);
      if (v < 1) return 1;
      if (v > SIDE_LIM) return SIDE_LIM;
      return v;
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < NODE_SLOTS; i++) begin
         tree_value[i] = INIT_VALUE;
         tree_low[i]   = '0;
         tree_known[i] = 1'b0;
      end
   endfunction

   function automatic void build_levels();
      int w;
      int h;
      int off;
      int n;
      w = grid_w;
      h = grid_h;
      off = 0;
      lvl_num = 0;
      do begin
         n = w * h;
         lvl_w[lvl_num] = w;
         lvl_off[lvl_num] = off;
         off = off + n;
         w = (w + 1) / 2;
         h = (h + 1) / 2;
         lvl_num++;
      end while (n > 1 && lvl_num < 32);
   endfunction

   function automatic int node_of(input int l, input int x, input int y);
      int i;
      i = lvl_off[l] + (y >> l) * lvl_w[l] + (x >> l);
      return (i < NODE_SLOTS) ? i : 0;
   endfunction

   // walks root to leaf and queues the coded bits
   function automatic void encode_leaf(input int x, input int y, input int thr);
      int low;
      int nd;
      int first;
      coded_bit_type cb;
      first = coded_q.size();
      low = 0;
      if (thr > THR_LIM) thr = THR_LIM;
      for (int l = lvl_num - 1; l >= 0; l--) begin
         nd = node_of(l, x, y);
         if (low > tree_low[nd]) tree_low[nd] = low[5:0];
         else low = tree_low[nd];
         while (low < thr) begin
            if (low >= tree_value[nd]) begin
               if (!tree_known[nd]) begin
                  cb.bit_res = 1'b1;
                  cb.last = 1'b0;
                  coded_q.push_back(cb);
                  tree_known[nd] = 1'b1;
               end
               break;
            end
            cb.bit_res = 1'b0;
            cb.last = 1'b0;
            coded_q.push_back(cb);
            low++;
         end
         tree_low[nd] = low[5:0];
      end
      if (coded_q.size() > first) coded_q[coded_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void apply_item(input logic [CMD_W-1:0] cmd, input int idx,
                                      input int val, input int thr);
      int x;
      int y;
      int nd;
      if (cmd == CMD_RESET) begin
         clear_tree();
         return;
      end
      if (cmd != CMD_SET && cmd != CMD_ENCODE) return;
      if (idx >= grid_w * grid_h) return;
      x = idx % grid_w;
      y = idx / grid_w;
      if (cmd == CMD_SET) begin
         for (int l = 0; l < lvl_num; l++) begin
            nd = node_of(l, x, y);
            if (tree_value[nd] <= val) break;
            tree_value[nd] = val[VAL_W-1:0];
         end
      end else begin
         encode_leaf(x, y, thr);
      end
   endfunction

   always @(posedge clock) begin
      coded_bit_type want;
      if (reset) begin
         grid_w = 1;
         grid_h = 1;
         clear_tree();
         build_levels();
         coded_q.delete();
         bits_checked = 0;
         errors = 0;
      end else begin
         // results first: a bit can leave while the next item is taken
         if (rsp_valid && rsp_ready) begin
            bits_checked++;
            if (coded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected bit: expected none, actual bit %0b last %0b",
                        $time, rsp_bit_res, rsp_last);
            end else begin
               want = coded_q.pop_front();
               if (rsp_bit_res !== want.bit_res) begin
                  errors++;
                  $display("%0t: bit_res mismatch: expected %0b, actual %0b",
                           $time, want.bit_res, rsp_bit_res);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
         if (req_valid && req_ready)
            apply_item(req_cmd, req_leaf_index, req_leaf_value, req_threshold);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH || csr_index == CSR_GRID_HEIGHT) begin
               if (csr_index == CSR_GRID_WIDTH) grid_w = clamp_side(csr_wdata);
               else grid_h = clamp_side(csr_wdata);
               clear_tree();
               build_levels();
            end
         end
      end
   end

endmodule

/* tb/sv/tag_tree_encoder_top_test.sv */
`timescale 1ns / 1ps
module tag_tree_encoder_top_test;
   import ttenc_pkg::*;

   // command value the block has no use for
   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd2;
   // set or encode can still be busy with no bit pending; a set walks up to 7 levels
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 90;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = CMD_RESET;
   logic [IDX_W-1:0]     req_leaf_index = '0;
   logic [VAL_W-1:0]     req_leaf_value = '0;
   logic [THR_W-1:0]     req_threshold = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_bit_res;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   int pending_bits;
   int bits_checked;
   int errors;
   int idle_pct;
   int stall_pct;
   int items_sent;
   int cycles = 0;
   int cur_w;
   int cur_h;

   tag_tree_encoder_top u_dut (.*);

   tag_tree_encoder_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver side: random stalls at the phase's rate
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // present one item and hold it until taken; gaps only between items
   task automatic send_item(input logic [CMD_W-1:0] cmd, input int idx, input int val,
                            input int thr);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_leaf_index <= idx[IDX_W-1:0];
      req_leaf_value <= val[VAL_W-1:0];
      req_threshold  <= thr[THR_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // block must be idle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bits != 0 || !req_ready) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // waits until the block is back in idle, then writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_valid <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[DIM_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int side_of(input int v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   // mostly small values so thresholds actually reach them
   function automatic int pick_value();
      if ($urandom_range(9) == 0) return $urandom_range(1023);
      return $urandom_range(0, 60);
   endfunction

   function automatic int pick_index();
      if ($urandom_range(99) < 12) return $urandom_range(4095);
      return $urandom_range(0, cur_w * cur_h - 1);
   endfunction

   int phase_w [PHASES] = '{0, 64, 127, 7, 33};
   int phase_h [PHASES] = '{0, 64, 5, 127, 64};
   int phase_idle [PHASES] = '{0, 50, 0, 16, 0};
   int phase_stall [PHASES] = '{0, 0, 50, 16, 0};

   initial begin
      int leaf;
      int thr;
      int r;
      idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: 4x3 grid gives three levels with ragged edges
      write_reg(CSR_GRID_WIDTH, 4);
      write_reg(CSR_GRID_HEIGHT, 3);
      cur_w = 4;
      cur_h = 3;
      send_item(CMD_SET, 0, 0, 0);
      send_item(CMD_SET, 5, 3, 0);
      send_item(CMD_SET, 11, 1023, 0);
      send_item(CMD_ENCODE, 0, 0, 0);         // zero threshold, no bits
      send_item(CMD_ENCODE, 0, 0, 1);
      send_item(CMD_ENCODE, 5, 0, 63);        // threshold saturates
      send_item(CMD_ENCODE, 5, 0, 10);        // already known, nothing new
      send_item(CMD_ENCODE, 11, 0, 63);
      send_item(CMD_ENCODE, 11, 0, 63);
      send_item(CMD_SET, 4095, 7, 0);         // leaf index out of range
      send_item(CMD_ENCODE, 4095, 0, 5);
      send_item(CMD_ENCODE, 12, 0, 5);        // first index past the grid
      send_item(CMD_UNUSED, 1, 1, 9);
      send_item(CMD_ENCODE, 3, 0, 20);        // never set: counts up to threshold
      send_item(CMD_RESET, 0, 0, 0);
      send_item(CMD_SET, 7, 2, 0);
      send_item(CMD_ENCODE, 7, 0, 40);
      send_item(CMD_ENCODE, 6, 0, 40);        // shares parent with leaf 7
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_GRID_WIDTH, phase_w[p]);
         write_reg(CSR_GRID_HEIGHT, phase_h[p]);
         if (p == 3) write_reg(CSR_SPARE, 5);
         cur_w = side_of(phase_w[p]);
         cur_h = side_of(phase_h[p]);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(99);
            leaf = pick_index();
            if (r < 30) begin
               // set then encode the same leaf with rising thresholds
               send_item(CMD_SET, leaf, pick_value(), $urandom_range(63));
               thr = $urandom_range(0, 30);
               send_item(CMD_ENCODE, leaf, $urandom_range(1023), thr);
               send_item(CMD_ENCODE, leaf, $urandom_range(1023),
                         thr + $urandom_range(0, 33));
               i += 2;
            end else if (r < 55) begin
               send_item(CMD_SET, leaf, pick_value(), $urandom_range(63));
            end else if (r < 96) begin
               send_item(CMD_ENCODE, leaf, $urandom_range(1023), $urandom_range(63));
            end else if (r < 99) begin
               send_item(CMD_UNUSED, $urandom_range(4095), $urandom_range(1023),
                         $urandom_range(63));
            end else begin
               send_item(CMD_RESET, $urandom_range(4095), $urandom_range(1023),
                         $urandom_range(63));
            end
         end
         drain();
      end

      stall_pct = 0;
      $display("sent %0d items over %0d grid settings, checked %0d coded bits",
               items_sent, PHASES + 1, bits_checked);
      if (errors == 0 && pending_bits == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d bits never seen", errors, pending_bits);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
